>>> rtl/pstk_pkg.sv
`timescale 1ns / 1ps

package pstk_pkg;

   // Request kinds carried on req_tuser.
   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   // Result status codes.
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_FULL       = 2'd1;
   localparam logic [1:0] STATUS_EMPTY      = 2'd2;

   // Width of the count field in a result.
   localparam int COUNT_BITS = 5;

   // Shift command broadcast to every cell of the row.
   typedef struct packed {
      logic push_en;
      logic pop_en;
   } pstk_ctrl_type;

endpackage

>>> rtl/priority_stack_top.sv
`timescale 1ns / 1ps

// Bounded priority stack: entries are kept sorted with the highest priority
// at the front, and among equal priorities the most recently pushed entry is
// served first. A request on req_ carries a kind in req_tuser (0 push, 1 pop)
// and, for a push, the element and its priority in req_tdata. Every request
// produces exactly one result on rsp_ with the front element and priority
// after the request, the entry count, an empty flag and a status code
// (0 ok, 1 push refused because the store is full, 2 pop refused because it
// is empty); a refused request leaves the store unchanged. The store is a row
// of CAPACITY cells that all compare against the incoming priority and shift
// toward the back on a push or toward the front on a pop all at once, so
// the block takes one request per cycle unless held off, and the result is
// registered in the output register on the edge that accepts it. A request is
// held off only while that output register is full and not being taken.
// Reset empties the store at once; no clearing pass is needed.

module priority_stack_top #(
   parameter int CAPACITY      = 16,
   parameter int ELEM_BITS     = 32,
   parameter int PRIORITY_BITS = 8
) (
   input  logic clock,
   input  logic reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   // Fields from bit 0: elem_in, priority_in, zero padding.
   input  logic [((ELEM_BITS + PRIORITY_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // Fields from bit 0: mode.
   input  logic                   req_tuser,

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // Fields from bit 0: top_elem, top_priority, count, is_empty, status,
   // zero padding.
   output logic [((ELEM_BITS + PRIORITY_BITS + pstk_pkg::COUNT_BITS + 10) / 8) * 8 - 1:0]
                                  rsp_tdata
);

   localparam int RSP_RAW   = ELEM_BITS + PRIORITY_BITS + pstk_pkg::COUNT_BITS + 3;
   localparam int RSP_BITS  = ((RSP_RAW + 7) / 8) * 8;
   localparam int CNT_BITS  = $clog2(CAPACITY + 1);
   localparam int PRIO_LSB  = ELEM_BITS;
   localparam int CNT_LSB   = ELEM_BITS + PRIORITY_BITS;
   localparam int EMPTY_BIT = CNT_LSB + pstk_pkg::COUNT_BITS;
   localparam int STAT_LSB  = EMPTY_BIT + 1;

   logic [ELEM_BITS-1:0]     new_elem;
   logic [PRIORITY_BITS-1:0] new_prio;
   logic                     req_accept;

   pstk_pkg::pstk_ctrl_type  ctrl;

   logic [ELEM_BITS-1:0]     cell_elem  [CAPACITY];
   logic [PRIORITY_BITS-1:0] cell_prio  [CAPACITY];
   logic [CAPACITY-1:0]      cell_valid;
   logic [CAPACITY-1:0]      cell_yield;

   logic [CNT_BITS-1:0]      count_ff, count_in;
   logic [RSP_BITS-1:0]      rsp_data_ff, rsp_data_in;
   logic                     rsp_valid_ff;

   logic [ELEM_BITS-1:0]     front_elem;
   logic [PRIORITY_BITS-1:0] front_prio;
   logic [1:0]               status;
   logic                     full;

   assign new_elem   = req_tdata[ELEM_BITS-1:0];
   assign new_prio   = req_tdata[PRIO_LSB +: PRIORITY_BITS];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign full       = (count_ff == CNT_BITS'(CAPACITY));

   // Row of cells; cell 0 is the front. On a push each cell takes its left
   // neighbor when the new entry lands ahead of that neighbor, takes the new
   // entry when it lands exactly here, and otherwise keeps its contents. On a
   // pop each cell takes its right neighbor.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ELEM_BITS-1:0]     l_elem, r_elem;
      logic [PRIORITY_BITS-1:0] l_prio, r_prio;
      logic                     l_valid, l_yield, r_valid;

      if (i == 0) begin : g_first
         assign l_elem  = new_elem;
         assign l_prio  = new_prio;
         assign l_valid = 1'b0;
         assign l_yield = 1'b0;
      end else begin : g_inner_left
         assign l_elem  = cell_elem[i-1];
         assign l_prio  = cell_prio[i-1];
         assign l_valid = cell_valid[i-1];
         assign l_yield = cell_yield[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign r_elem  = cell_elem[i];
         assign r_prio  = cell_prio[i];
         assign r_valid = 1'b0;
      end else begin : g_inner_right
         assign r_elem  = cell_elem[i+1];
         assign r_prio  = cell_prio[i+1];
         assign r_valid = cell_valid[i+1];
      end

      pstk_cell #(
         .ELEM_BITS     (ELEM_BITS),
         .PRIORITY_BITS (PRIORITY_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_elem    (new_elem),
         .new_prio    (new_prio),
         .left_elem   (l_elem),
         .left_prio   (l_prio),
         .left_valid  (l_valid),
         .left_yield  (l_yield),
         .right_elem  (r_elem),
         .right_prio  (r_prio),
         .right_valid (r_valid),
         .elem        (cell_elem[i]),
         .prio        (cell_prio[i]),
         .valid       (cell_valid[i]),
         .yield       (cell_yield[i])
      );
   end

   // Decode the request and work out the front entry as it will stand after
   // the row has shifted, so the result can be registered in the same edge.
   always_comb begin
      ctrl       = '0;
      count_in   = count_ff;
      status     = pstk_pkg::STATUS_OK;
      front_elem = cell_elem[0];
      front_prio = cell_prio[0];
      if (req_accept) begin
         if (req_tuser == pstk_pkg::MODE_PUSH) begin
            if (full) begin
               status = pstk_pkg::STATUS_FULL;
            end else begin
               ctrl.push_en = 1'b1;
               count_in     = CNT_BITS'(count_ff + 1'b1);
               if (cell_yield[0]) begin
                  front_elem = new_elem;
                  front_prio = new_prio;
               end
            end
         end else begin
            if (count_ff == '0) begin
               status = pstk_pkg::STATUS_EMPTY;
            end else begin
               ctrl.pop_en = 1'b1;
               count_in    = CNT_BITS'(count_ff - 1'b1);
               front_elem  = cell_elem[1];
               front_prio  = cell_prio[1];
            end
         end
      end
   end

   always_comb begin
      rsp_data_in = '0;
      if (count_in != '0) begin
         rsp_data_in[ELEM_BITS-1:0]               = front_elem;
         rsp_data_in[PRIO_LSB +: PRIORITY_BITS]   = front_prio;
      end
      rsp_data_in[CNT_LSB +: pstk_pkg::COUNT_BITS] = pstk_pkg::COUNT_BITS'(count_in);
      rsp_data_in[EMPTY_BIT]                       = (count_in == '0);
      rsp_data_in[STAT_LSB +: 2]                   = status;
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The entry count always matches the number of occupied cells.
   a_count_matches_cells : assert property (
      @(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(count_ff)
   ) else $error("entry count disagrees with occupied cells");

   // Occupied cells form an unbroken run starting at the front.
   a_cells_packed_front : assert property (
      @(posedge clock) disable iff (reset)
      ((cell_valid + 1'b1) & cell_valid) == '0
   ) else $error("occupied cells are not packed toward the front");

   // A successful pop removes exactly one entry.
   a_pop_decrements : assert property (
      @(posedge clock) disable iff (reset)
      (req_accept && req_tuser == pstk_pkg::MODE_POP && count_ff != '0)
      |=> count_ff == CNT_BITS'($past(count_ff) - 1'b1)
   ) else $error("pop did not remove exactly one entry");

   // A push into a full store leaves the cell occupancy and the front element as they were.
   a_full_push_holds : assert property (
      @(posedge clock) disable iff (reset)
      (req_accept && req_tuser == pstk_pkg::MODE_PUSH && full)
      |=> $stable(cell_valid) && cell_elem[0] == $past(cell_elem[0])
   ) else $error("refused push changed the store");

   // A result is never overwritten before it has been taken.
   a_no_result_overwrite : assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_accept
   ) else $error("request accepted while a result was stalled");

endmodule

>>> rtl/pstk_cell.sv
`timescale 1ns / 1ps

module pstk_cell #(
   parameter int ELEM_BITS     = 32,
   parameter int PRIORITY_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pstk_pkg::pstk_ctrl_type  ctrl,
   input  logic [ELEM_BITS-1:0]     new_elem,
   input  logic [PRIORITY_BITS-1:0] new_prio,
   input  logic [ELEM_BITS-1:0]     left_elem,
   input  logic [PRIORITY_BITS-1:0] left_prio,
   input  logic                     left_valid,
   input  logic                     left_yield,
   input  logic [ELEM_BITS-1:0]     right_elem,
   input  logic [PRIORITY_BITS-1:0] right_prio,
   input  logic                     right_valid,
   output logic [ELEM_BITS-1:0]     elem,
   output logic [PRIORITY_BITS-1:0] prio,
   output logic                     valid,
   output logic                     yield
);

   logic [ELEM_BITS-1:0]     elem_ff, elem_in;
   logic [PRIORITY_BITS-1:0] prio_ff, prio_in;
   logic                     valid_ff, valid_in;

   // The new entry belongs at or ahead of this cell when the cell is empty
   // or holds a priority no higher than the new one.
   assign yield = !valid_ff || (prio_ff <= new_prio);

   always_comb begin
      elem_in  = elem_ff;
      prio_in  = prio_ff;
      valid_in = valid_ff;
      if (ctrl.push_en) begin
         if (left_yield) begin
            elem_in  = left_elem;
            prio_in  = left_prio;
            valid_in = left_valid;
         end else if (yield) begin
            elem_in  = new_elem;
            prio_in  = new_prio;
            valid_in = 1'b1;
         end
      end else if (ctrl.pop_en) begin
         elem_in  = right_elem;
         prio_in  = right_prio;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
      prio_ff <= prio_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign elem  = elem_ff;
   assign prio  = prio_ff;
   assign valid = valid_ff;

endmodule
